/* rtl/core/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared constants, codes and types of the ordered list core.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 7;
  localparam int ST_W     = 2;
  localparam int FILL_W   = 7;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int OP_W     = 5;

  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DEDUP  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NOP       = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_APPEND    = 5'd2;
  localparam op_t OP_SET_FULL  = 5'd3;
  localparam op_t OP_SET_RANGE = 5'd4;
  localparam op_t OP_UP_RD     = 5'd5;
  localparam op_t OP_UP_WR     = 5'd6;
  localparam op_t OP_INS_WR    = 5'd7;
  localparam op_t OP_RM_RD     = 5'd8;
  localparam op_t OP_RM_CAP    = 5'd9;
  localparam op_t OP_DN_RD     = 5'd10;
  localparam op_t OP_DN_WR     = 5'd11;
  localparam op_t OP_RM_FIN    = 5'd12;
  localparam op_t OP_DD_RDI    = 5'd13;
  localparam op_t OP_DD_CAPI   = 5'd14;
  localparam op_t OP_DD_RDK    = 5'd15;
  localparam op_t OP_DD_KEEP   = 5'd16;
  localparam op_t OP_DD_SKIP   = 5'd17;
  localparam op_t OP_DD_NEXTK  = 5'd18;
  localparam op_t OP_DD_FIN    = 5'd19;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              ins_range;
    logic              rm_range;
    logic              up_done;
    logic              dn_done;
    logic              i_done;
    logic              k_done;
    logic              match;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/ordered_list_insert_remove_dedup_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_dedup_core
// Dense ordered list of signed 32-bit values: append, insert, remove, dedup.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------
//  in_      | start / busy      | in_func, in_position, in_value_in
//  out_     | out_valid (pulse) | out_status, out_removed_value, out_fill_count
//
//  One request at a time; busy is high from acceptance until the strobe.
//  Append and rejected requests finish right after dispatch. Insert shifts the
//  entries from position up, then writes the value; remove captures the entry
//  and shifts the later ones down. Dedup compares each entry with those kept so
//  far. Shift and compare steps read the entry RAM, whose read is registered.
//  Reset empties the list at once; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_remove_dedup_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic        [olist_pkg::FUNC_W-1:0]   in_func,
  input  wire logic        [olist_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [olist_pkg::DATA_W-1:0]   in_value_in,
  output logic                                       out_valid,
  output logic             [olist_pkg::ST_W-1:0]     out_status,
  output logic signed      [olist_pkg::DATA_W-1:0]   out_removed_value,
  output logic             [olist_pkg::FILL_W-1:0]   out_fill_count
);

  olist_pkg::cmd_t  cmd;
  olist_pkg::stat_t stat;

  olist_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (out_valid)
  );

  olist_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_func),
    .in_position(in_position),
    .in_value_in(in_value_in),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (out_status),
    .res_removed(out_removed_value),
    .res_fill   (out_fill_count)
  );

endmodule

`default_nettype wire

/* rtl/core/olist_ram.sv */
// ----------------------------------------------------------------------------
// olist_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/olist_dp.sv */
// ----------------------------------------------------------------------------
// olist_dp
// List datapath: entry RAM, fill count, walk indices and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [olist_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [olist_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [olist_pkg::DATA_W-1:0] in_value_in,
  input  wire olist_pkg::cmd_t                cmd,
  output olist_pkg::stat_t                    stat,
  output logic      [olist_pkg::ST_W-1:0]     res_status,
  output logic signed [olist_pkg::DATA_W-1:0] res_removed,
  output logic      [olist_pkg::FILL_W-1:0]   res_fill
);

  localparam int AW = olist_pkg::ADDR_W;
  localparam int CW = olist_pkg::CNT_W;
  localparam int MW = olist_pkg::CMP_W;
  localparam int DW = olist_pkg::DATA_W;

  logic [olist_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [olist_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [DW-1:0]                val_r, val_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                i_r, i_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic [CW-1:0]                kept_r, kept_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [olist_pkg::ST_W-1:0]   status_r, status_nxt;
  logic [DW-1:0]                removed_r, removed_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_p1;

  olist_ram #(
    .WIDTH(DW),
    .DEPTH(olist_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign idx_m1 = idx_r - 1'b1;
  assign idx_p1 = idx_r + 1'b1;

  always_comb begin
    func_nxt    = func_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    kept_nxt    = kept_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    we          = 1'b0;
    waddr       = idx_r[AW-1:0];
    wdata       = rdata;
    raddr       = '0;
    unique case (cmd.op)
      olist_pkg::OP_LOAD: begin
        func_nxt    = in_func;
        pos_nxt     = in_position;
        val_nxt     = in_value_in;
        idx_nxt     = count_r;
        i_nxt       = '0;
        k_nxt       = '0;
        kept_nxt    = '0;
        status_nxt  = olist_pkg::ST_OK;
        removed_nxt = '0;
      end
      olist_pkg::OP_APPEND: begin
        we        = 1'b1;
        waddr     = count_r[AW-1:0];
        wdata     = val_r;
        count_nxt = count_r + 1'b1;
      end
      olist_pkg::OP_SET_FULL:  status_nxt = olist_pkg::ST_FULL;
      olist_pkg::OP_SET_RANGE: status_nxt = olist_pkg::ST_RANGE;
      olist_pkg::OP_UP_RD:     raddr = idx_m1[AW-1:0];
      olist_pkg::OP_UP_WR: begin
        we      = 1'b1;
        idx_nxt = idx_m1;
      end
      olist_pkg::OP_INS_WR: begin
        we        = 1'b1;
        waddr     = AW'(pos_r);
        wdata     = val_r;
        count_nxt = count_r + 1'b1;
      end
      olist_pkg::OP_RM_RD: begin
        raddr   = AW'(pos_r);
        idx_nxt = CW'(pos_r);
      end
      olist_pkg::OP_RM_CAP:    removed_nxt = rdata;
      olist_pkg::OP_DN_RD:     raddr = idx_p1[AW-1:0];
      olist_pkg::OP_DN_WR: begin
        we      = 1'b1;
        idx_nxt = idx_p1;
      end
      olist_pkg::OP_RM_FIN:    count_nxt = count_r - 1'b1;
      olist_pkg::OP_DD_RDI:    raddr = i_r[AW-1:0];
      olist_pkg::OP_DD_CAPI: begin
        val_nxt = rdata;
        k_nxt   = '0;
      end
      olist_pkg::OP_DD_RDK:    raddr = k_r[AW-1:0];
      olist_pkg::OP_DD_KEEP: begin
        we       = 1'b1;
        waddr    = kept_r[AW-1:0];
        wdata    = val_r;
        kept_nxt = kept_r + 1'b1;
        i_nxt    = i_r + 1'b1;
      end
      olist_pkg::OP_DD_SKIP:   i_nxt = i_r + 1'b1;
      olist_pkg::OP_DD_NEXTK:  k_nxt = k_r + 1'b1;
      olist_pkg::OP_DD_FIN:    count_nxt = kept_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    kept_r    <= kept_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  always_comb begin
    stat.func      = func_r;
    stat.full      = (count_r >= CW'(olist_pkg::CAPACITY));
    stat.ins_range = (MW'(pos_r) > MW'(count_r));
    stat.rm_range  = (MW'(pos_r) >= MW'(count_r));
    stat.up_done   = (MW'(idx_r) == MW'(pos_r));
    stat.dn_done   = ((MW'(idx_r) + MW'(1)) >= MW'(count_r));
    stat.i_done    = (i_r >= count_r);
    stat.k_done    = (k_r >= kept_r);
    stat.match     = (rdata == val_r);
  end

  assign res_status  = status_r;
  assign res_removed = removed_r;
  assign res_fill    = olist_pkg::FILL_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(olist_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == olist_pkg::OP_APPEND) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("append did not grow the list by one");

  a_dedup_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == olist_pkg::OP_DD_KEEP) |-> (kept_r <= i_r))
    else $error("dedup write ahead of scan");

endmodule

`default_nettype wire

/* rtl/core/olist_ctrl.sv */
// ----------------------------------------------------------------------------
// olist_ctrl
// Sequencer: dispatches each request and steps the shift and dedup walks.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire olist_pkg::stat_t stat,
  output olist_pkg::cmd_t       cmd,
  output logic                  busy,
  output logic                  done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_UP   = 4'd2;
  localparam logic [3:0] S_UPW  = 4'd3;
  localparam logic [3:0] S_RMC  = 4'd4;
  localparam logic [3:0] S_DN   = 4'd5;
  localparam logic [3:0] S_DNW  = 4'd6;
  localparam logic [3:0] S_DDI  = 4'd7;
  localparam logic [3:0] S_DDC  = 4'd8;
  localparam logic [3:0] S_DDK  = 4'd9;
  localparam logic [3:0] S_DDM  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = olist_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = olist_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.func)
          olist_pkg::FN_APPEND: begin
            cmd.op    = stat.full ? olist_pkg::OP_SET_FULL : olist_pkg::OP_APPEND;
            state_nxt = S_DONE;
          end
          olist_pkg::FN_INSERT: begin
            priority if (stat.ins_range) begin
              cmd.op    = olist_pkg::OP_SET_RANGE;
              state_nxt = S_DONE;
            end else if (stat.full) begin
              cmd.op    = olist_pkg::OP_SET_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_UP;
            end
          end
          olist_pkg::FN_REMOVE: begin
            if (stat.rm_range) begin
              cmd.op    = olist_pkg::OP_SET_RANGE;
              state_nxt = S_DONE;
            end else begin
              cmd.op    = olist_pkg::OP_RM_RD;
              state_nxt = S_RMC;
            end
          end
          olist_pkg::FN_DEDUP: state_nxt = S_DDI;
          default: state_nxt = S_DONE;
        endcase
      end
      S_UP: begin
        if (stat.up_done) begin
          cmd.op    = olist_pkg::OP_INS_WR;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = olist_pkg::OP_UP_RD;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        cmd.op    = olist_pkg::OP_UP_WR;
        state_nxt = S_UP;
      end
      S_RMC: begin
        cmd.op    = olist_pkg::OP_RM_CAP;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (stat.dn_done) begin
          cmd.op    = olist_pkg::OP_RM_FIN;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = olist_pkg::OP_DN_RD;
          state_nxt = S_DNW;
        end
      end
      S_DNW: begin
        cmd.op    = olist_pkg::OP_DN_WR;
        state_nxt = S_DN;
      end
      S_DDI: begin
        if (stat.i_done) begin
          cmd.op    = olist_pkg::OP_DD_FIN;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = olist_pkg::OP_DD_RDI;
          state_nxt = S_DDC;
        end
      end
      S_DDC: begin
        cmd.op    = olist_pkg::OP_DD_CAPI;
        state_nxt = S_DDK;
      end
      S_DDK: begin
        if (stat.k_done) begin
          cmd.op    = olist_pkg::OP_DD_KEEP;
          state_nxt = S_DDI;
        end else begin
          cmd.op    = olist_pkg::OP_DD_RDK;
          state_nxt = S_DDM;
        end
      end
      S_DDM: begin
        if (stat.match) begin
          cmd.op    = olist_pkg::OP_DD_SKIP;
          state_nxt = S_DDI;
        end else begin
          cmd.op    = olist_pkg::OP_DD_NEXTK;
          state_nxt = S_DDK;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not occupy the sequencer");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

endmodule

`default_nettype wire

/* dv/olist_checker.sv */
// ----------------------------------------------------------------------------
// olist_checker
// Watches the request and result channels of the ordered list core. It keeps
// a shadow copy of the list, works out the outcome of every accepted request
// and compares each result strobe, field by field, with the oldest outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic        [olist_pkg::FUNC_W-1:0] in_func,
  input  wire logic        [olist_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [olist_pkg::DATA_W-1:0] in_value_in,
  input  wire logic                                out_valid,
  input  wire logic        [olist_pkg::ST_W-1:0]   out_status,
  input  wire logic signed [olist_pkg::DATA_W-1:0] out_removed_value,
  input  wire logic        [olist_pkg::FILL_W-1:0] out_fill_count,
  output int                                       fail_count,
  output int                                       awaited,
  output int                                       list_fill
);

  localparam int AW = olist_pkg::ADDR_W;
  localparam int DW = olist_pkg::DATA_W;

  typedef struct packed {
    logic        [olist_pkg::ST_W-1:0]   status;
    logic signed [DW-1:0]                removed;
    logic        [olist_pkg::FILL_W-1:0] fill;
  } outcome_t;

  logic signed [DW-1:0] shadow_entries [0:olist_pkg::CAPACITY-1];
  int                   shadow_count = 0;
  outcome_t             due_outcomes [$];
  int                   mismatches = 0;
  int                   due_level = 0;
  int                   fill_level = 0;

  assign fail_count = mismatches;
  assign awaited    = due_level;
  assign list_fill  = fill_level;

  task automatic report_mismatch(input string field, input logic [DW-1:0] want,
                                 input logic [DW-1:0] got);
    mismatches++;
    $display("mismatch on %s: expected 0x%0h, got 0x%0h (t=%0t)", field, want, got, $time);
  endtask

  // Applies one request to the shadow list and returns its outcome.
  task automatic list_apply(input logic [olist_pkg::FUNC_W-1:0] fn,
                            input logic [olist_pkg::POS_W-1:0] pos,
                            input logic signed [DW-1:0] val, output outcome_t res);
    int  p;
    int  kept;
    int  k;
    bit  seen;
    logic signed [DW-1:0] v;
    p           = pos;
    res.status  = olist_pkg::ST_OK;
    res.removed = '0;
    case (fn)
      olist_pkg::FN_APPEND: begin
        if (shadow_count >= olist_pkg::CAPACITY) begin
          res.status = olist_pkg::ST_FULL;
        end else begin
          shadow_entries[AW'(shadow_count)] = val;
          shadow_count++;
        end
      end
      olist_pkg::FN_INSERT: begin
        if (p > shadow_count) begin
          res.status = olist_pkg::ST_RANGE;
        end else if (shadow_count >= olist_pkg::CAPACITY) begin
          res.status = olist_pkg::ST_FULL;
        end else begin
          for (int j = shadow_count; j > p; j--)
            shadow_entries[AW'(j)] = shadow_entries[AW'(j - 1)];
          shadow_entries[AW'(p)] = val;
          shadow_count++;
        end
      end
      olist_pkg::FN_REMOVE: begin
        if (p >= shadow_count) begin
          res.status = olist_pkg::ST_RANGE;
        end else begin
          res.removed = shadow_entries[AW'(p)];
          for (int j = p; j + 1 < shadow_count; j++)
            shadow_entries[AW'(j)] = shadow_entries[AW'(j + 1)];
          shadow_count--;
        end
      end
      default: begin
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          v    = shadow_entries[AW'(i)];
          seen = 1'b0;
          for (k = 0; k < kept && !seen; k++)
            if (shadow_entries[AW'(k)] == v) seen = 1'b1;
          if (!seen) begin
            shadow_entries[AW'(kept)] = v;
            kept++;
          end
        end
        shadow_count = kept;
      end
    endcase
    res.fill = shadow_count[olist_pkg::FILL_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      shadow_count = 0;
      due_outcomes.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (due_outcomes.size() == 0) begin
          report_mismatch("unrequested result", '0, '1);
        end else begin
          want = due_outcomes.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", DW'(want.status), DW'(out_status));
          if (out_removed_value !== want.removed)
            report_mismatch("removed_value", want.removed, out_removed_value);
          if (out_fill_count !== want.fill)
            report_mismatch("fill_count", DW'(want.fill), DW'(out_fill_count));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        list_apply(in_func, in_position, in_value_in, want);
        due_outcomes.push_back(want);
      end
    end
    due_level  <= due_outcomes.size();
    fill_level <= shadow_count;
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the ordered list core: a directed pass over range,
// empty-list and dedup cases, then random phases that lean towards growing
// or shrinking the list, with varying sender gaps. The checker predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int FW = olist_pkg::FUNC_W;
  localparam int PW = olist_pkg::POS_W;
  localparam int DW = olist_pkg::DATA_W;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic        [FW-1:0]                in_func = '0;
  logic        [PW-1:0]                in_position = '0;
  logic signed [DW-1:0]                in_value_in = '0;
  logic                                out_valid;
  logic        [olist_pkg::ST_W-1:0]   out_status;
  logic signed [DW-1:0]                out_removed_value;
  logic        [olist_pkg::FILL_W-1:0] out_fill_count;
  int                                  fail_count;
  int                                  awaited;
  int                                  list_fill;

  logic signed [DW-1:0] value_pool [0:7];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ordered_list_insert_remove_dedup_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_fill_count    (out_fill_count)
  );

  olist_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_fill_count    (out_fill_count),
    .fail_count        (fail_count),
    .awaited           (awaited),
    .list_fill         (list_fill)
  );

  // Called at a falling edge; holds the request until it is taken.
  task automatic issue(input logic [FW-1:0] fn, input logic [PW-1:0] pos,
                       input logic signed [DW-1:0] val);
    start       <= 1'b1;
    in_func     <= fn;
    in_position <= pos;
    in_value_in <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic send_request(input logic [FW-1:0] fn, input logic [PW-1:0] pos,
                              input logic signed [DW-1:0] val);
    @(negedge clk);
    issue(fn, pos, val);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int n_items, input bit hold_mid);
    int                   mode;
    int                   r;
    int                   c;
    logic        [FW-1:0] fn;
    logic        [PW-1:0] pos;
    logic signed [DW-1:0] val;
    mode = 2;
    for (int item = 0; item < n_items; item++) begin
      if (hold_mid && item == n_items / 2) drain();
      if (item % 60 == 0) mode = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < idle_pct) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          start <= 1'b0;
        end
      end
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 4) fn = olist_pkg::FN_DEDUP;
      else if (mode == 0)
        fn = (r < 60) ? olist_pkg::FN_APPEND :
             (r < 85) ? olist_pkg::FN_INSERT : olist_pkg::FN_REMOVE;
      else if (mode == 1)
        fn = (r < 20) ? olist_pkg::FN_APPEND :
             (r < 35) ? olist_pkg::FN_INSERT : olist_pkg::FN_REMOVE;
      else
        fn = (r < 35) ? olist_pkg::FN_APPEND :
             (r < 60) ? olist_pkg::FN_INSERT : olist_pkg::FN_REMOVE;
      case ($urandom_range(0, 3))
        0, 1: val = value_pool[3'($urandom_range(0, 7))];
        2: val = $urandom;
        default: begin
          case ($urandom_range(0, 4))
            0: val = 32'sh7FFF_FFFF;
            1: val = 32'sh8000_0000;
            2: val = '0;
            3: val = '1;
            default: val = 32'sd1;
          endcase
        end
      endcase
      c = list_fill;
      r = $urandom_range(0, 99);
      if (r < 70) pos = PW'($urandom_range(0, c));
      else if (r < 85) pos = PW'(c + $urandom_range(0, 1));
      else pos = PW'($urandom_range(0, 127));
      issue(fn, pos, val);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) value_pool[3'(i)] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, range edges, extremes, dedup
    send_request(olist_pkg::FN_REMOVE, 7'd0, 32'sd0);
    send_request(olist_pkg::FN_DEDUP, 7'd0, 32'sd0);
    send_request(olist_pkg::FN_INSERT, 7'd1, 32'sd5);
    send_request(olist_pkg::FN_INSERT, 7'd0, 32'sd7);
    send_request(olist_pkg::FN_APPEND, 7'd127, 32'sh7FFF_FFFF);
    send_request(olist_pkg::FN_APPEND, 7'd0, 32'sh8000_0000);
    send_request(olist_pkg::FN_APPEND, 7'd0, 32'sd0);
    send_request(olist_pkg::FN_APPEND, 7'd0, -32'sd1);
    send_request(olist_pkg::FN_INSERT, 7'd2, 32'sd7);
    send_request(olist_pkg::FN_INSERT, 7'd6, 32'sh8000_0000);
    send_request(olist_pkg::FN_REMOVE, 7'd7, 32'sd0);
    send_request(olist_pkg::FN_REMOVE, 7'd127, 32'sd0);
    send_request(olist_pkg::FN_INSERT, 7'd127, 32'sd3);
    send_request(olist_pkg::FN_INSERT, 7'd8, 32'sd3);
    send_request(olist_pkg::FN_DEDUP, 7'd0, 32'sd0);
    send_request(olist_pkg::FN_DEDUP, 7'd64, 32'sd0);
    send_request(olist_pkg::FN_REMOVE, 7'd4, 32'sd0);
    send_request(olist_pkg::FN_REMOVE, 7'd0, 32'sd0);
    send_request(olist_pkg::FN_APPEND, 7'd0, 32'sh5555_5555);
    send_request(olist_pkg::FN_INSERT, 7'd0, 32'shAAAA_AAAA);
    send_request(olist_pkg::FN_REMOVE, 7'd1, 32'sd0);
    drain();

    run_phase(0, 250, 1'b0);
    run_phase(55, 250, 1'b1);
    run_phase(24, 250, 1'b0);
    run_phase(0, 250, 1'b0);

    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ordered_list_insert_remove_dedup_core verification clean");
    else
      $display("ordered_list_insert_remove_dedup_core verification failed");
    $finish;
  end

  initial begin
    #700_000_000;
    $display("ordered_list_insert_remove_dedup_core verification failed");
    $finish;
  end

endmodule
